/* rtl/wfba_pkg.sv */
// Package for the worst-fit block allocator: payload words, sequencer states, codes.
`default_nettype none

package wfba_pkg;

    // Fixed field widths of the channel words
    localparam int unsigned OP_W     = 1;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned AMOUNT_W = 16;
    localparam int unsigned CFG_W    = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

    // Reset value of the search count register
    localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

    // Input word
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [INDEX_W-1:0]  block_index;
        logic [AMOUNT_W-1:0] amount;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic                granted;
        logic [INDEX_W-1:0]  chosen_block;
        logic [AMOUNT_W-1:0] original_size;
        logic [AMOUNT_W-1:0] remaining_size;
    } out_word_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FETCH,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

/* rtl/worst_fit_block_allocator_unit.sv */
// Worst-fit block allocator: size tables, scan sequencer and result register.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid / in_stall | op, block_index, amount
//  out     | output    | out_valid/out_stall | granted, chosen_block, original_size, ...
//  cfg     | input     | cfg_valid/cfg_ready | blocks_in_use (5 bits)
//
// A request scans entries 0 .. N-1 one per cycle through the single read port of the
// free-size memory, N = min(blocks_in_use, MAX_BLOCKS); the memory read port and the one
// comparator set the pace. When N is 0 the request goes straight to the finish state.
// Reset clears the sequencer, the result valid and sets blocks_in_use to 16; the size
// memories are not cleared. While a result waits under out_stall the next word is taken,
// and a request then holds in its last state until the result register is free.
`default_nettype none

module worst_fit_block_allocator_unit
    import wfba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = 16,
    parameter int unsigned SIZE_BITS  = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // input channel
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_word_t         in_data,
    // result channel
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_word_t             out_data,
    // configuration channel
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

    // Size memories
    logic [SIZE_BITS-1:0] free_mem   [MAX_BLOCKS];
    logic [SIZE_BITS-1:0] loaded_mem [MAX_BLOCKS];

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [SIZE_BITS-1:0] amt_reg, amt_next;
    logic                 found_reg, found_next;
    logic [SIZE_BITS-1:0] best_size_reg, best_size_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic                 out_valid_reg, out_valid_next;
    out_word_t            out_data_reg, out_data_next;
    logic [CFG_W-1:0]     blocks_reg;

    logic [SIZE_BITS-1:0] free_rd_reg;
    logic [SIZE_BITS-1:0] loaded_rd_reg;

    logic                 free_we;
    logic [IDX_W-1:0]     free_waddr;
    logic [SIZE_BITS-1:0] free_wdata;
    logic                 loaded_we;
    logic [IDX_W-1:0]     load_addr;
    logic [SIZE_BITS-1:0] in_amt;
    logic                 load_in_range;
    logic [CNT_W-1:0]     limit;
    logic [SIZE_BITS-1:0] remain;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    // Input decode
    assign in_amt        = SIZE_BITS'(in_data.amount);
    assign load_addr     = IDX_W'(in_data.block_index);
    assign load_in_range = (32'(in_data.block_index) < MAX_BLOCKS);
    assign remain        = best_size_reg - amt_reg;

    // Search count saturates at the table depth
    always_comb
    begin
        if (32'(blocks_reg) >= MAX_BLOCKS)
        begin
            limit = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            limit = CNT_W'(blocks_reg);
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_reg <= BLOCKS_IN_USE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            blocks_reg <= cfg_data;
        end
    end

    // Memories: one write port each, registered reads
    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[free_waddr] <= free_wdata;
        end
        free_rd_reg <= free_mem[scan_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (loaded_we)
        begin
            loaded_mem[load_addr] <= in_amt;
        end
        loaded_rd_reg <= loaded_mem[best_idx_reg];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            scan_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            scan_reg      <= scan_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        amt_reg       <= amt_next;
        best_size_reg <= best_size_next;
        best_idx_reg  <= best_idx_next;
        out_data_reg  <= out_data_next;
    end

    // Sequencer, comparator and result build
    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        amt_next       = amt_reg;
        found_next     = found_reg;
        best_size_next = best_size_reg;
        best_idx_next  = best_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        free_we        = 1'b0;
        free_waddr     = load_addr;
        free_wdata     = in_amt;
        loaded_we      = 1'b0;

        // shared compare on the word read last cycle; strict > keeps the lowest index
        if (cmp_valid_reg && (free_rd_reg >= amt_reg)
            && (!found_reg || (free_rd_reg > best_size_reg)))
        begin
            found_next     = 1'b1;
            best_size_next = free_rd_reg;
            best_idx_next  = cmp_idx_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                scan_next = '0;
                if (in_valid)
                begin
                    if (in_data.op == OP_LOAD)
                    begin
                        free_we   = load_in_range;
                        loaded_we = load_in_range;
                    end
                    else
                    begin
                        amt_next       = in_amt;
                        found_next     = 1'b0;
                        best_size_next = '0;
                        best_idx_next  = '0;
                        if (limit == '0)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                cmp_valid_next = 1'b1;
                cmp_idx_next   = scan_reg[IDX_W-1:0];
                if ((scan_reg + CNT_W'(1)) == limit)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            // last entry is compared here
            ST_LAST:
            begin
                state_next = ST_FETCH;
            end

            // loaded size of the winner is read here
            ST_FETCH:
            begin
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (found_reg)
                    begin
                        free_we                      = 1'b1;
                        free_waddr                   = best_idx_reg;
                        free_wdata                   = remain;
                        out_data_next.granted        = 1'b1;
                        out_data_next.chosen_block   = INDEX_W'(best_idx_reg);
                        out_data_next.original_size  = AMOUNT_W'(loaded_rd_reg);
                        out_data_next.remaining_size = AMOUNT_W'(remain);
                    end
                    else
                    begin
                        out_data_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
